// ===== design/ikeda_pkg.sv =====
// ----------------------------------------------------------------------------
// Ikeda map iterator package
// Shared types and constants for the fixed-point Ikeda map datapath.
// ----------------------------------------------------------------------------
package ikeda_pkg;

   localparam int CordicSteps = 24;
   localparam int StepW       = 5;

   localparam logic signed [63:0] FxOne    = 64'sd16777216;
   localparam logic signed [63:0] FxPi     = 64'sd52707179;
   localparam logic signed [63:0] FxTwoPi  = 64'sd105414357;
   localparam logic signed [63:0] FxHalfPi = 64'sd26353589;
   localparam logic signed [63:0] FxGain   = 64'sd10188014;
   localparam logic signed [63:0] Lim32    = 64'sd4294967295;

   // Reciprocal of two pi, scaled so that the integer part of an angle times
   // this value, shifted right by 32, never exceeds the true turn count.
   localparam logic [63:0] FxRecip = (64'd1 << 56) / FxTwoPi;

   typedef enum logic [2:0] {
      CSR_INIT_X = 3'd0,
      CSR_INIT_Y = 3'd1,
      CSR_COEF_A = 3'd2,
      CSR_COEF_B = 3'd3,
      CSR_COEF_C = 3'd4,
      CSR_COEF_D = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_DIV, ST_ANG, ST_MOD, ST_RED, ST_CORD,
      ST_XC, ST_YS, ST_XS, ST_YC, ST_BX, ST_BY
   } state_type;

   function automatic logic signed [63:0] atan_entry(input logic [StepW-1:0] i);
      logic signed [63:0] r;
      unique case (i)
         5'd0: r = 64'sd13176795;  5'd1: r = 64'sd7778716;
         5'd2: r = 64'sd4110060;   5'd3: r = 64'sd2086331;
         5'd4: r = 64'sd1047214;   5'd5: r = 64'sd524117;
         5'd6: r = 64'sd262123;    5'd7: r = 64'sd131069;
         5'd8: r = 64'sd65536;     5'd9: r = 64'sd32768;
         5'd10: r = 64'sd16384;    5'd11: r = 64'sd8192;
         5'd12: r = 64'sd4096;     5'd13: r = 64'sd2048;
         5'd14: r = 64'sd1024;     5'd15: r = 64'sd512;
         5'd16: r = 64'sd256;      5'd17: r = 64'sd128;
         5'd18: r = 64'sd64;       5'd19: r = 64'sd32;
         5'd20: r = 64'sd16;       5'd21: r = 64'sd8;
         5'd22: r = 64'sd4;        5'd23: r = 64'sd2;
         5'd24: r = 64'sd1;
         default: r = 64'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/ikeda_div.sv =====
// ----------------------------------------------------------------------------
// Ikeda restoring divider
// Unsigned 56 by 64 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ikeda_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [55:0] quotient
);
   import ikeda_pkg::*;

   logic [55:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[55]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd55;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[54:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in    = 64'(trial - {1'b0, divisor});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[63:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd0);
   assign quotient = {quo_ff[54:0], (trial >= {1'b0, divisor})};
endmodule

// ===== design/ikeda_map_iterator.sv =====
// ----------------------------------------------------------------------------
// Ikeda map iterator
// Chaotic Ikeda map generator in signed Q7.24 fixed point.
// ----------------------------------------------------------------------------
// A restart item reloads the point from init_x and init_y and returns it on
// the cycle after it is accepted. A tick item returns the current point on the
// next cycle, then advances it; the block takes no new item until it is done,
// through two squaring passes, the bit-serial divider, reciprocal angle
// reduction, range correction until the angle lies in range, the 24 CORDIC
// iterations and six passes through one shared 33 by 33 bit multiplier. The
// result can wait in the output register while the next point is being
// computed, but a new item is only taken once that result has been read.
module ikeda_map_iterator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] x_out, [63:32] y_out
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ikeda_pkg::*;

   logic signed [31:0] init_x_ff, init_y_ff, a_ff, b_ff, c_ff, d_ff;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   state_type          st_ff, st_in;
   logic signed [63:0] acc_ff, acc_in, t_ff, t_in;
   logic signed [63:0] cx_ff, cx_in, cy_ff, cy_in, rx_ff, rx_in, ry_ff, ry_in;
   logic               neg_ff, neg_in;
   logic [StepW-1:0]   i_ff, i_in;
   logic               ov_ff, ov_in;
   logic [63:0]        out_ff, out_in;
   logic               div_start, div_done;
   logic [55:0]        div_q;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod, bsh, sum_b;
   logic signed [63:0] shx, shy, sv, cv, abs_t, rem, rx_v, ry_v;
   logic signed [31:0] sat_b;
   logic               in_range;
   logic               accept;

   assign req_tready = (st_ff == ST_IDLE) && !ov_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_x_ff <= '0;
         init_y_ff <= '0;
         a_ff      <= 32'sd14260634;
         b_ff      <= 32'sd15099494;
         c_ff      <= 32'sd6710886;
         d_ff      <= 32'sd129184154;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INIT_X: init_x_ff <= csr_wdata;
            CSR_INIT_Y: init_y_ff <= csr_wdata;
            CSR_COEF_A: a_ff      <= csr_wdata;
            CSR_COEF_B: b_ff      <= csr_wdata;
            CSR_COEF_C: c_ff      <= csr_wdata;
            CSR_COEF_D: d_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   ikeda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({d_ff[31] ? 32'(-d_ff) : 32'(d_ff), 24'd0}),
      .divisor  (64'(acc_ff)),
      .done     (div_done),
      .quotient (div_q)
   );

   assign in_range = (t_ff <= FxPi) && (t_ff > FxPi - FxTwoPi);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (accept && !req_tdata[0]) st_in = ST_SQX;
         ST_SQX:  st_in = ST_SQY;
         ST_SQY:  st_in = ST_DIV;
         ST_DIV:  if (div_done) st_in = ST_ANG;
         ST_ANG:  st_in = ST_MOD;
         ST_MOD:  st_in = ST_RED;
         ST_RED:  if (in_range) st_in = ST_CORD;
         ST_CORD: if (i_ff == StepW'(CordicSteps - 1)) st_in = ST_XC;
         ST_XC:   st_in = ST_YS;
         ST_YS:   st_in = ST_XS;
         ST_XS:   st_in = ST_YC;
         ST_YC:   st_in = ST_BX;
         ST_BX:   st_in = ST_BY;
         ST_BY:   st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = 33'(px_ff);
      mul_b = 33'(px_ff);
      unique case (st_ff)
         ST_SQY:  begin mul_a = 33'(py_ff); mul_b = 33'(py_ff); end
         ST_ANG:  begin mul_a = {1'b0, abs_t[55:24]}; mul_b = 33'(FxRecip); end
         ST_MOD:  begin mul_a = acc_ff[32:0]; mul_b = 33'(FxTwoPi); end
         ST_XC:   mul_b = cv[32:0];
         ST_YS:   begin mul_a = 33'(py_ff); mul_b = sv[32:0]; end
         ST_XS:   mul_b = sv[32:0];
         ST_YC:   begin mul_a = 33'(py_ff); mul_b = cv[32:0]; end
         ST_BX:   begin mul_a = 33'(b_ff); mul_b = rx_ff[32:0]; end
         ST_BY:   begin mul_a = 33'(b_ff); mul_b = ry_ff[32:0]; end
         default: ;
      endcase
   end
   assign prod = 66'(mul_a) * 66'(mul_b);

   always_comb begin
      abs_t = t_ff[63] ? -t_ff : t_ff;
      rem   = abs_t - 64'(prod);
      rx_v  = (acc_ff - 64'(prod)) >>> 24;
      ry_v  = (acc_ff + 64'(prod)) >>> 24;
      bsh   = prod >>> 24;
      sum_b = bsh + ((st_ff == ST_BX) ? 66'(a_ff) : 66'sd0);
      sat_b = (sum_b > 66'sd2147483647) ? 32'sh7fffffff :
              (sum_b < -66'sd2147483648) ? 32'sh80000000 : 32'(sum_b);
      shx   = cx_ff >>> i_ff;
      shy   = cy_ff >>> i_ff;
      cv    = neg_ff ? -cx_ff : cx_ff;
      sv    = neg_ff ? -cy_ff : cy_ff;
   end

   always_comb begin
      acc_in    = acc_ff;
      t_in      = t_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      neg_in    = neg_ff;
      i_in      = i_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      ov_in     = ov_ff;
      out_in    = out_ff;
      div_start = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (accept) begin
            ov_in = 1'b1;
            if (req_tdata[0]) begin
               px_in  = init_x_ff;
               py_in  = init_y_ff;
               out_in = {init_y_ff, init_x_ff};
            end else begin
               out_in = {py_ff, px_ff};
            end
         end
         ST_SQX: acc_in = 64'(prod);
         ST_SQY: begin
            acc_in    = 64'((acc_ff + 64'(prod)) >> 24) + FxOne;
            div_start = 1'b1;
         end
         ST_DIV: if (div_done) begin
            t_in = 64'(c_ff) - (d_ff[31] ? -$signed({8'd0, div_q})
                                         : $signed({8'd0, div_q}));
         end
         ST_ANG: acc_in = {30'd0, prod[65:32]};
         ST_MOD: t_in = t_ff[63] ? -rem : rem;
         ST_RED: begin
            if (t_ff > FxPi) begin
               t_in = t_ff - FxTwoPi;
            end else if (t_ff <= FxPi - FxTwoPi) begin
               t_in = t_ff + FxTwoPi;
            end else begin
               neg_in = 1'b0;
               if (t_ff > FxHalfPi) begin
                  t_in = t_ff - FxPi; neg_in = 1'b1;
               end else if (t_ff < -FxHalfPi) begin
                  t_in = t_ff + FxPi; neg_in = 1'b1;
               end
               cx_in = FxGain;
               cy_in = '0;
               i_in  = '0;
            end
         end
         ST_CORD: begin
            if (t_ff >= 0) begin
               cx_in = cx_ff - shy; cy_in = cy_ff + shx;
               t_in  = t_ff - atan_entry(i_ff);
            end else begin
               cx_in = cx_ff + shy; cy_in = cy_ff - shx;
               t_in  = t_ff + atan_entry(i_ff);
            end
            i_in = i_ff + 1'b1;
         end
         ST_XC: acc_in = 64'(prod);
         ST_YS: rx_in = (rx_v > Lim32) ? Lim32 : ((rx_v < -Lim32) ? -Lim32 : rx_v);
         ST_XS: acc_in = 64'(prod);
         ST_YC: ry_in = (ry_v > Lim32) ? Lim32 : ((ry_v < -Lim32) ? -Lim32 : ry_v);
         ST_BX: px_in = sat_b;
         ST_BY: py_in = sat_b;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         px_ff <= '0;
         py_ff <= '0;
         i_ff  <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         i_ff  <= i_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
      acc_ff <= acc_in;
      t_ff   <= t_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      neg_ff <= neg_in;
      out_ff <= out_in;
   end
endmodule
